>>> rtl/core/arx_pkg.sv
`timescale 1ns / 1ps

package arx_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned COEF_FRAC = 14;
  localparam int unsigned PACKED_TAPS = 3;
  localparam int unsigned PACKED_W  = COEF_W * PACKED_TAPS;
  localparam int unsigned DELAY_CFG_W = 5;
  localparam int unsigned LIMIT_EN_W  = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = PACKED_W;

  localparam int unsigned NA_DEFAULT        = 3;
  localparam int unsigned NB_DEFAULT        = 3;
  localparam int unsigned MAX_DELAY_DEFAULT = 16;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A     = 3'd0,
    REG_COEF_B     = 3'd1,
    REG_DELAY      = 3'd2,
    REG_INPUT_MIN  = 3'd3,
    REG_INPUT_MAX  = 3'd4,
    REG_OUTPUT_MIN = 3'd5,
    REG_OUTPUT_MAX = 3'd6,
    REG_LIMIT_EN   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       hit;
  } limit_t;

  function automatic logic signed [COEF_W-1:0] coef_tap(
    input logic [PACKED_W-1:0] packed_v,
    input int unsigned         idx
  );
    logic signed [COEF_W-1:0] res;
    res = '0;
    if (idx < PACKED_TAPS) begin
      res = packed_v[COEF_W*idx +: COEF_W];
    end
    return res;
  endfunction

  function automatic limit_t limit_val(
    input logic signed [SAMPLE_W-1:0] v,
    input logic signed [SAMPLE_W-1:0] lo,
    input logic signed [SAMPLE_W-1:0] hi
  );
    limit_t res;
    res.value = v;
    res.hit   = 1'b0;
    if (v < lo) begin
      res.value = lo;
      res.hit   = 1'b1;
    end else if (v > hi) begin
      res.value = hi;
      res.hit   = 1'b1;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/arx_ram.sv
`timescale 1ns / 1ps

module arx_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read of the entry being written returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/arx_plant_model_step.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+------------------------------------------
// in       | in  | in_valid_i / in_stall_o | control_in_i, noise_sample_i
// out      | out | out_valid_o/ out_stall_i| plant_output_o, input_clamped_o,
//          |     |                         | output_clamped_o
// cfg      | in  | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One request per cycle while in_stall_o is low. Stage one reads the delay line RAM,
// stage two forms the feedforward sum, stage three closes the output feedback loop
// and loads the result register. Reset clears all history at once; the delay line is
// tracked by a fill count, no clearing pass. Stalls hold only the stages that are
// full; bubbles still collapse.

module arx_plant_model_step
  import arx_pkg::*;
#(
  parameter int unsigned NA        = arx_pkg::NA_DEFAULT,
  parameter int unsigned NB        = arx_pkg::NB_DEFAULT,
  parameter int unsigned MAX_DELAY = arx_pkg::MAX_DELAY_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  cfg_we_i,
  input  logic [arx_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [arx_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,

  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [arx_pkg::SAMPLE_W-1:0]   control_in_i,
  input  logic signed [arx_pkg::SAMPLE_W-1:0]   noise_sample_i,

  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [arx_pkg::SAMPLE_W-1:0]   plant_output_o,
  output logic                                  input_clamped_o,
  output logic                                  output_clamped_o
);

  localparam int unsigned AW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int unsigned DW    = $clog2(MAX_DELAY + 1);
  localparam int unsigned PW    = DW + 1;
  localparam int unsigned PROD_W = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W = PROD_W + $clog2(NA + NB + 1) + 2;

  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(SAMPLE_MIN);

  // configuration
  logic [PACKED_W-1:0]        coef_a_q;
  logic [PACKED_W-1:0]        coef_b_q;
  logic [DW-1:0]              delay_q;
  logic signed [SAMPLE_W-1:0] in_min_q;
  logic signed [SAMPLE_W-1:0] in_max_q;
  logic signed [SAMPLE_W-1:0] out_min_q;
  logic signed [SAMPLE_W-1:0] out_max_q;
  logic [LIMIT_EN_W-1:0]      lim_en_q;

  logic [DELAY_CFG_W-1:0]     delay_wr;
  logic [DW-1:0]              delay_eff;

  // delay line bookkeeping
  logic [AW-1:0]              wp_q;
  logic [DW-1:0]              fill_q;
  logic [PW-1:0]              raddr_ext;
  logic [AW-1:0]              raddr;
  logic [SAMPLE_W-1:0]        ram_rdata;

  // handshake
  logic                       out_ready;
  logic                       b_ready;
  logic                       a_ready;
  logic                       accept;

  // stage A: RAM read in flight
  logic                       valid_a_q;
  logic                       dly_ok_a_q;
  logic signed [SAMPLE_W-1:0] noise_a_q;
  logic                       hit_a_q;

  // stage B: feedforward sum
  logic                       valid_b_q;
  logic signed [ACC_W-1:0]    ff_q;
  logic signed [ACC_W-1:0]    ff_d;
  logic                       hit_b_q;

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic                       in_hit_q;
  logic                       out_hit_q;

  logic signed [SAMPLE_W-1:0] uh_q [NB];
  logic signed [SAMPLE_W-1:0] uh_d [NB];
  logic signed [SAMPLE_W-1:0] yh_q [NA];

  limit_t                     u_lim;
  limit_t                     y_lim;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    q;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       sat_hit;
  logic signed [SAMPLE_W-1:0] y_d;
  logic                       out_hit_d;

  // ---------------------------------------------------------------- config
  assign delay_wr = cfg_wdata_i[DELAY_CFG_W-1:0];

  always_comb begin
    if (delay_wr == '0) begin
      delay_eff = DW'(1);
    end else if (32'(delay_wr) > MAX_DELAY) begin
      delay_eff = DW'(MAX_DELAY);
    end else begin
      delay_eff = DW'(delay_wr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q  <= '0;
      coef_b_q  <= '0;
      delay_q   <= DW'(1);
      in_min_q  <= SAMPLE_MIN;
      in_max_q  <= SAMPLE_MAX;
      out_min_q <= SAMPLE_MIN;
      out_max_q <= SAMPLE_MAX;
      lim_en_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_A:     coef_a_q  <= cfg_wdata_i[PACKED_W-1:0];
        REG_COEF_B:     coef_b_q  <= cfg_wdata_i[PACKED_W-1:0];
        REG_DELAY:      delay_q   <= delay_eff;
        REG_INPUT_MIN:  in_min_q  <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_INPUT_MAX:  in_max_q  <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_OUTPUT_MIN: out_min_q <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_OUTPUT_MAX: out_max_q <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_LIMIT_EN:   lim_en_q  <= cfg_wdata_i[LIMIT_EN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign b_ready    = !valid_b_q || out_ready;
  assign a_ready    = !valid_a_q || b_ready;
  assign accept     = in_valid_i && a_ready;
  assign in_stall_o = !a_ready;

  // ---------------------------------------------------------------- delay line
  always_comb begin
    if (lim_en_q[0]) begin
      u_lim = limit_val(control_in_i, in_min_q, in_max_q);
    end else begin
      u_lim.value = control_in_i;
      u_lim.hit   = 1'b0;
    end
  end

  always_comb begin
    if (PW'(wp_q) >= PW'(delay_q)) begin
      raddr_ext = PW'(wp_q) - PW'(delay_q);
    end else begin
      raddr_ext = PW'(wp_q) + PW'(MAX_DELAY) - PW'(delay_q);
    end
  end
  assign raddr = raddr_ext[AW-1:0];

  arx_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_DELAY)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(wp_q),
    .wdata_i(u_lim.value),
    .re_i   (a_ready),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // drop everything written before a delay change
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == REG_DELAY && delay_eff != delay_q) begin
      fill_q <= '0;
    end else if (accept) begin
      if (32'(wp_q) == MAX_DELAY - 1) begin
        wp_q <= '0;
      end else begin
        wp_q <= wp_q + AW'(1);
      end
      if (32'(fill_q) < MAX_DELAY) begin
        fill_q <= fill_q + DW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage A
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (a_ready) begin
      valid_a_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dly_ok_a_q <= (fill_q >= delay_q);
      noise_a_q  <= noise_sample_i;
      hit_a_q    <= u_lim.hit;
    end
  end

  // ---------------------------------------------------------------- stage B
  assign delayed = dly_ok_a_q ? $signed(ram_rdata) : '0;

  always_comb begin
    uh_d[0] = delayed;
    for (int i = 1; i < NB; i++) begin
      uh_d[i] = uh_q[i-1];
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    ff_d = ACC_W'(noise_a_q) <<< COEF_FRAC;
    for (int i = 0; i < NB; i++) begin
      prod = coef_tap(coef_b_q, i) * uh_d[i];
      ff_d = ff_d + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        uh_q[i] <= '0;
      end
    end else if (b_ready) begin
      valid_b_q <= valid_a_q;
      if (valid_a_q) begin
        for (int i = 0; i < NB; i++) begin
          uh_q[i] <= uh_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && valid_a_q) begin
      ff_q    <= ff_d;
      hit_b_q <= hit_a_q;
    end
  end

  // ---------------------------------------------------------------- feedback
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    acc = ff_q;
    for (int i = 0; i < NA; i++) begin
      prod = coef_tap(coef_a_q, i) * yh_q[i];
      acc  = acc - ACC_W'(prod);
    end
  end

  // arithmetic shift floors, which matches the rounding of the sum
  assign q = acc >>> COEF_FRAC;

  always_comb begin
    sat_hit = 1'b0;
    if (q > Q_MAX) begin
      y_sat   = SAMPLE_MAX;
      sat_hit = 1'b1;
    end else if (q < Q_MIN) begin
      y_sat   = SAMPLE_MIN;
      sat_hit = 1'b1;
    end else begin
      y_sat = q[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    if (lim_en_q[1]) begin
      y_lim = limit_val(y_sat, out_min_q, out_max_q);
    end else begin
      y_lim.value = y_sat;
      y_lim.hit   = 1'b0;
    end
    y_d       = y_lim.value;
    out_hit_d = sat_hit || y_lim.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        yh_q[i] <= '0;
      end
    end else if (out_ready) begin
      out_valid_q <= valid_b_q;
      if (valid_b_q) begin
        yh_q[0] <= y_d;
        for (int i = 1; i < NA; i++) begin
          yh_q[i] <= yh_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && valid_b_q) begin
      y_q       <= y_d;
      in_hit_q  <= hit_b_q;
      out_hit_q <= out_hit_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign plant_output_o   = y_q;
  assign input_clamped_o  = in_hit_q;
  assign output_clamped_o = out_hit_q;

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_DELAY)
    else $error("delay line fill count beyond depth");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) < MAX_DELAY)
    else $error("delay line write pointer out of range");

  a_delay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q != '0 && 32'(delay_q) <= MAX_DELAY)
    else $error("effective delay out of range");

  a_take_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_a_q |-> !in_stall_o)
    else $error("request stalled while first stage is empty");

  a_feedback_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_b_q && out_ready) |=> out_valid_q)
    else $error("feedback stage result lost");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import arx_pkg::*;

  localparam int unsigned TAPS_A        = NA_DEFAULT;
  localparam int unsigned TAPS_B        = NB_DEFAULT;
  localparam int unsigned DLY_DEPTH     = MAX_DELAY_DEFAULT;
  localparam int unsigned RUN_LIMIT     = 200000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 70;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned PRINT_CAP     = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t ctl;
    sample_t noise;
  } plant_req_t;

  typedef struct {
    sample_t y;
    logic    in_hit;
    logic    out_hit;
  } plant_result_t;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i        = REG_COEF_A;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i      = '0;
  logic                   in_valid_i       = 1'b0;
  logic                   in_stall_o;
  sample_t                control_in_i     = '0;
  sample_t                noise_sample_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i      = 1'b0;
  sample_t                plant_output_o;
  logic                   input_clamped_o;
  logic                   output_clamped_o;

  plant_req_t     ctl_req_q[$];
  plant_result_t  plant_y_q[$];

  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 0;
  int unsigned hold_left    = 0;
  int unsigned seen_results = 0;
  logic        hold_done    = 1'b0;

  // plant mirror: configuration and history
  logic [PACKED_W-1:0]   mdl_coef_a;
  logic [PACKED_W-1:0]   mdl_coef_b;
  int unsigned           mdl_delay;
  sample_t               mdl_in_lo;
  sample_t               mdl_in_hi;
  sample_t               mdl_out_lo;
  sample_t               mdl_out_hi;
  logic [LIMIT_EN_W-1:0] mdl_clamp_en;
  sample_t               dly_line [DLY_DEPTH];
  sample_t               u_hist [TAPS_B];
  sample_t               y_hist [TAPS_A];

  arx_plant_model_step DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic plant_result_t plant_step(input sample_t ctl, input sample_t noise);
    plant_result_t      res;
    sample_t            u;
    sample_t            delayed;
    logic signed [63:0] acc;
    logic signed [63:0] q;
    res.in_hit  = 1'b0;
    res.out_hit = 1'b0;
    u = ctl;
    if (mdl_clamp_en[0]) begin
      if (u < mdl_in_lo) begin
        u = mdl_in_lo;
        res.in_hit = 1'b1;
      end else if (u > mdl_in_hi) begin
        u = mdl_in_hi;
        res.in_hit = 1'b1;
      end
    end
    delayed = dly_line[mdl_delay - 1];
    for (int i = DLY_DEPTH - 1; i > 0; i--) dly_line[i] = dly_line[i - 1];
    dly_line[0] = u;
    for (int i = TAPS_B - 1; i > 0; i--) u_hist[i] = u_hist[i - 1];
    u_hist[0] = delayed;
    acc = 64'(noise);
    acc = acc <<< COEF_FRAC;
    for (int i = 0; i < TAPS_B; i++) begin
      acc = acc + $signed(mdl_coef_b[COEF_W*i +: COEF_W]) * u_hist[i];
    end
    for (int i = 0; i < TAPS_A; i++) begin
      acc = acc - $signed(mdl_coef_a[COEF_W*i +: COEF_W]) * y_hist[i];
    end
    q = acc >>> COEF_FRAC;
    if (q > SAMPLE_MAX) begin
      res.y = SAMPLE_MAX;
      res.out_hit = 1'b1;
    end else if (q < SAMPLE_MIN) begin
      res.y = SAMPLE_MIN;
      res.out_hit = 1'b1;
    end else begin
      res.y = q[SAMPLE_W-1:0];
    end
    if (mdl_clamp_en[1]) begin
      if (res.y < mdl_out_lo) begin
        res.y = mdl_out_lo;
        res.out_hit = 1'b1;
      end else if (res.y > mdl_out_hi) begin
        res.y = mdl_out_hi;
        res.out_hit = 1'b1;
      end
    end
    for (int i = TAPS_A - 1; i > 0; i--) y_hist[i] = y_hist[i - 1];
    y_hist[0] = res.y;
    return res;
  endfunction

  function automatic logic [PACKED_W-1:0] taps(input int t0, input int t1, input int t2);
    return {COEF_W'(t2), COEF_W'(t1), COEF_W'(t0)};
  endfunction

  function automatic logic [COEF_W-1:0] small_coef();
    return COEF_W'(int'($urandom_range(0, 8192)) - 4096);
  endfunction

  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
    if (pick < 4) return sample_t'(int'($urandom_range(0, 4096)) - 2048);
    return sample_t'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    end
  endtask

  task automatic add_req(input int ctl, input int noise);
    plant_req_t req;
    req.ctl   = sample_t'(ctl);
    req.noise = sample_t'(noise);
    ctl_req_q.insert(ctl_req_q.size(), req);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    int unsigned d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_COEF_A:     mdl_coef_a = val[PACKED_W-1:0];
      REG_COEF_B:     mdl_coef_b = val[PACKED_W-1:0];
      REG_DELAY: begin
        d = 32'(val[DELAY_CFG_W-1:0]);
        if (d < 1) d = 1;
        else if (d > DLY_DEPTH) d = DLY_DEPTH;
        if (d != mdl_delay) begin
          mdl_delay = d;
          dly_line  = '{default: '0};
        end
      end
      REG_INPUT_MIN:  mdl_in_lo    = val[SAMPLE_W-1:0];
      REG_INPUT_MAX:  mdl_in_hi    = val[SAMPLE_W-1:0];
      REG_OUTPUT_MIN: mdl_out_lo   = val[SAMPLE_W-1:0];
      REG_OUTPUT_MAX: mdl_out_hi   = val[SAMPLE_W-1:0];
      REG_LIMIT_EN:   mdl_clamp_en = val[LIMIT_EN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_config(input logic [PACKED_W-1:0] a, input logic [PACKED_W-1:0] b,
                             input logic [DELAY_CFG_W-1:0] dly,
                             input sample_t ilo, input sample_t ihi,
                             input sample_t olo, input sample_t ohi,
                             input logic [LIMIT_EN_W-1:0] en);
    write_reg(REG_COEF_A, CFG_DATA_W'(a));
    write_reg(REG_COEF_B, CFG_DATA_W'(b));
    write_reg(REG_DELAY, CFG_DATA_W'(dly));
    write_reg(REG_INPUT_MIN, CFG_DATA_W'(ilo));
    write_reg(REG_INPUT_MAX, CFG_DATA_W'(ihi));
    write_reg(REG_OUTPUT_MIN, CFG_DATA_W'(olo));
    write_reg(REG_OUTPUT_MAX, CFG_DATA_W'(ohi));
    write_reg(REG_LIMIT_EN, CFG_DATA_W'(en));
    end_writes();
  endtask

  task automatic random_config(input int unsigned style);
    logic [PACKED_W-1:0]   a;
    logic [PACKED_W-1:0]   b;
    logic [DELAY_CFG_W-1:0] dly;
    sample_t               ilo;
    sample_t               ihi;
    sample_t               olo;
    sample_t               ohi;
    logic [LIMIT_EN_W-1:0] en;
    case (style)
      0: begin
        a = '1;
        b = '1;
        dly = '1;
        ilo = SAMPLE_MAX;
        ihi = SAMPLE_MAX;
        olo = SAMPLE_MAX;
        ohi = SAMPLE_MAX;
        en = '1;
      end
      1: begin
        a = {PACKED_TAPS{16'h8000}};
        b = {PACKED_TAPS{16'h8000}};
        dly = '0;
        ilo = SAMPLE_MIN;
        ihi = SAMPLE_MIN;
        olo = SAMPLE_MIN;
        ohi = SAMPLE_MIN;
        en = '1;
      end
      2: begin
        a = {small_coef(), small_coef(), small_coef()};
        b = {small_coef(), small_coef(), small_coef()};
        dly = DELAY_CFG_W'($urandom_range(1, DLY_DEPTH));
        ilo = sample_t'(-int'($urandom_range(0, 20000)));
        ihi = sample_t'($urandom_range(0, 20000));
        olo = sample_t'(-int'($urandom_range(0, 20000)));
        ohi = sample_t'($urandom_range(0, 20000));
        en = LIMIT_EN_W'($urandom_range(0, 3));
      end
      default: begin
        a = PACKED_W'({$urandom, $urandom});
        b = PACKED_W'({$urandom, $urandom});
        dly = DELAY_CFG_W'($urandom_range(0, 31));
        ilo = sample_t'($urandom);
        ihi = sample_t'($urandom);
        olo = sample_t'($urandom);
        ohi = sample_t'($urandom);
        en = LIMIT_EN_W'($urandom_range(0, 3));
      end
    endcase
    load_config(a, b, dly, ilo, ihi, olo, ohi, en);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (ctl_req_q.size() != 0 || in_valid_i || plant_y_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    mdl_coef_a   = '0;
    mdl_coef_b   = '0;
    mdl_delay    = 1;
    mdl_in_lo    = SAMPLE_MIN;
    mdl_in_hi    = SAMPLE_MAX;
    mdl_out_lo   = SAMPLE_MIN;
    mdl_out_hi   = SAMPLE_MAX;
    mdl_clamp_en = '0;
    dly_line     = '{default: '0};
    u_hist       = '{default: '0};
    y_hist       = '{default: '0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: output follows noise
    add_req(32767, 32767);
    add_req(-32768, -32768);
    add_req(0, 0);
    add_req(-1, 1);
    drain();

    // zero delay acts as one step, both clamps on
    load_config(taps(8192, -4096, 0), taps(16384, 8192, -16384), 5'd0,
                sample_t'(-256), sample_t'(256), sample_t'(-1000), sample_t'(1000),
                2'b11);
    add_req(32767, 0);
    add_req(-32768, 0);
    add_req(100, 50);
    add_req(256, -32768);
    add_req(-257, 32767);
    drain();

    // inverted limits on both sides, delay of three
    load_config(taps(8192, -4096, 0), taps(16384, 0, 0), 5'd3,
                sample_t'(500), sample_t'(-500), sample_t'(300), sample_t'(-300),
                2'b11);
    add_req(0, 0);
    add_req(1000, 0);
    add_req(-1000, 0);
    add_req(600, 40);
    drain();

    // rewrite the same delay: stored samples come out
    write_reg(REG_DELAY, CFG_DATA_W'(3));
    write_reg(REG_COEF_A, '0);
    write_reg(REG_LIMIT_EN, '0);
    end_writes();
    add_req(1, 0);
    add_req(2, 0);
    add_req(3, 0);
    drain();

    // delay above the line depth, saturating feedback
    load_config(taps(-32768, -32768, -32768), taps(32767, 32767, 32767), 5'd31,
                SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 2'b00);
    add_req(32767, 32767);
    add_req(-32768, -32768);
    add_req(0, 0);
    add_req(32767, -32768);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config((p < 2) ? p : 2 + (p % 2));
      for (int k = 0; k < PHASE_ITEMS; k++) add_req(rand_sample(), rand_sample());
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin : req_driver
    plant_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0 || ctl_req_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        req = ctl_req_q[0];
        ctl_req_q.delete(0);
        in_valid_i     <= 1'b1;
        control_in_i   <= req.ctl;
        noise_sample_i <= req.noise;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 4) == 0) begin
            burst_left <= $urandom_range(50, 150);
            gap_left   <= 0;
          end else begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= $urandom_range(0, 6);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : out_stall_gen
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) seen_results <= seen_results + 1;
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && seen_results >= HOLD_AFTER && in_valid_i) begin
        // hold off the output long enough to back up the input
        out_stall_i <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        hold_done   <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(10, 80);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : plant_monitor
    plant_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        plant_y_q.insert(plant_y_q.size(), plant_step(control_in_i, noise_sample_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (plant_y_q.size() == 0) begin
          report_mismatch("unexpected plant_output", plant_output_o, 0);
        end else begin
          want = plant_y_q[0];
          plant_y_q.delete(0);
          if (plant_output_o !== want.y) begin
            report_mismatch("plant_output", plant_output_o, want.y);
          end
          if (input_clamped_o !== want.in_hit) begin
            report_mismatch("input_clamped", input_clamped_o, want.in_hit);
          end
          if (output_clamped_o !== want.out_hit) begin
            report_mismatch("output_clamped", output_clamped_o, want.out_hit);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : run_watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
